// ===== sv/tlbs_pkg.sv =====
package tlbs_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int REM_W   = IDX_W + 1;
  // count / 2 is the dividend of the random pick
  localparam int DVD_W   = 31;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WR_IDX = 2'd1,
    FUNC_WR_RND = 2'd2,
    FUNC_PROBE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_RD_DATA,
    S_DIV,
    S_WR,
    S_SCAN,
    S_SCAN_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [18:0] vpn;
    logic [11:0] mask;
    logic [7:0]  asid;
    logic        glob;
    logic [23:0] frame_even;
    logic [23:0] frame_odd;
    logic [4:0]  attr_even;
    logic [4:0]  attr_odd;
  } tlb_entry_t;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             rd_en;
    logic             rd_scan;
    logic             cmp_en;
    logic             rd_capture;
    logic             wr_en;
    logic             wr_rnd;
    logic             publish;
    logic [IDX_W-1:0] step;
  } ctl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  hit;
  } dp_status_t;

  function automatic tlb_entry_t unpack_entry(input logic [31:0] hi,
                                              input logic [31:0] lo0,
                                              input logic [31:0] lo1,
                                              input logic [31:0] pm);
    tlb_entry_t e;
    e.vpn        = hi[31:13];
    e.mask       = pm[24:13];
    e.asid       = hi[7:0];
    e.glob       = lo0[0] & lo1[0];
    e.frame_even = lo0[29:6];
    e.frame_odd  = lo1[29:6];
    e.attr_even  = lo0[5:1];
    e.attr_odd   = lo1[5:1];
    return e;
  endfunction

  function automatic logic entry_match(input tlb_entry_t e,
                                       input logic [18:0] vpn,
                                       input logic [7:0]  asid);
    logic [18:0] keep;
    keep = ~{7'd0, e.mask};
    return ((e.vpn & keep) == (vpn & keep)) && (e.glob || (e.asid == asid));
  endfunction

endpackage

// ===== sv/tlbs_ctrl.sv =====
module tlbs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tlbs_pkg::dp_status_t  status,
  output tlbs_pkg::ctl_cmd_t    cmd
);

  tlbs_pkg::state_t                state_r, state_nxt;
  logic [tlbs_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlbs_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    in_stall  = 1'b1;

    unique case (state_r)
      tlbs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tlbs_pkg::S_DECODE;
        end
      end
      tlbs_pkg::S_DECODE: begin
        unique case (status.func)
          tlbs_pkg::FUNC_READ:   state_nxt = tlbs_pkg::S_RD;
          tlbs_pkg::FUNC_WR_IDX: state_nxt = tlbs_pkg::S_WR;
          tlbs_pkg::FUNC_WR_RND: begin
            state_nxt = tlbs_pkg::S_DIV;
            cnt_nxt   = tlbs_pkg::IDX_W'(tlbs_pkg::DVD_W - 1);
          end
          tlbs_pkg::FUNC_PROBE: begin
            state_nxt = tlbs_pkg::S_SCAN;
            cnt_nxt   = '0;
          end
          default: state_nxt = tlbs_pkg::S_DONE;
        endcase
      end
      tlbs_pkg::S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = tlbs_pkg::S_RD_DATA;
      end
      tlbs_pkg::S_RD_DATA: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = tlbs_pkg::S_DONE;
      end
      tlbs_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = tlbs_pkg::S_WR;
        else             cnt_nxt   = cnt_r - 1'b1;
      end
      tlbs_pkg::S_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_rnd = (status.func == tlbs_pkg::FUNC_WR_RND);
        state_nxt  = tlbs_pkg::S_DONE;
      end
      tlbs_pkg::S_SCAN: begin
        // issue entry cnt while checking the entry read in the cycle before
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
        cmd.cmp_en  = (cnt_r != '0);
        if (cmd.cmp_en && status.hit)
          state_nxt = tlbs_pkg::S_DONE;
        else if (cnt_r == tlbs_pkg::IDX_W'(tlbs_pkg::ENTRIES - 1))
          state_nxt = tlbs_pkg::S_SCAN_LAST;
        else
          cnt_nxt = cnt_r + 1'b1;
      end
      tlbs_pkg::S_SCAN_LAST: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = tlbs_pkg::S_DONE;
      end
      tlbs_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = tlbs_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlbs_pkg::S_IDLE;
    endcase

    out_valid_nxt = cmd.publish | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/tlbs_datapath.sv =====
module tlbs_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [4:0]                 cfg_wired_limit,
  input  logic [1:0]                 in_func,
  input  logic [4:0]                 in_entry_index,
  input  logic [31:0]                in_entry_hi,
  input  logic [31:0]                in_entry_lo_even,
  input  logic [31:0]                in_entry_lo_odd,
  input  logic [31:0]                in_page_mask,
  input  logic [31:0]                in_cycle_count,
  input  tlbs_pkg::ctl_cmd_t         cmd,
  output tlbs_pkg::dp_status_t       status,
  output logic [4:0]                 out_index_out,
  output logic                       out_probe_miss,
  output logic [31:0]                out_hi_out,
  output logic [29:0]                out_lo_even_out,
  output logic [29:0]                out_lo_odd_out,
  output logic [24:0]                out_mask_out
);

  localparam int IDX_W = tlbs_pkg::IDX_W;
  localparam int REM_W = tlbs_pkg::REM_W;

  // configuration
  logic [IDX_W-1:0]            wired_r;

  // latched item
  tlbs_pkg::func_t             func_r;
  logic [IDX_W-1:0]            idx_r;
  tlbs_pkg::tlb_entry_t        new_r;
  logic [tlbs_pkg::DVD_W-1:0]  dvd_r;

  // entry store
  tlbs_pkg::tlb_entry_t        mem [tlbs_pkg::ENTRIES];
  logic [tlbs_pkg::ENTRIES-1:0] valid_r;
  tlbs_pkg::tlb_entry_t        rd_data_r;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            rd_idx_r;
  tlbs_pkg::tlb_entry_t        rd_entry;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;

  // random pick remainder
  logic [REM_W-1:0]            rem_r;
  logic [REM_W-1:0]            divisor;
  logic [REM_W:0]              trial;
  logic [IDX_W-1:0]            rnd_addr;

  // working result
  logic [IDX_W-1:0]            res_index_r;
  logic                        res_miss_r;
  logic [31:0]                 res_hi_r;
  logic [29:0]                 res_lo_even_r;
  logic [29:0]                 res_lo_odd_r;
  logic [24:0]                 res_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) wired_r <= '0;
    else if (cfg_we) wired_r <= cfg_wired_limit;
  end

  assign divisor  = REM_W'(tlbs_pkg::ENTRIES) - {1'b0, wired_r};
  assign trial    = {rem_r, dvd_r[cmd.step]};
  assign rnd_addr = rem_r[IDX_W-1:0] + wired_r;
  assign rd_addr  = cmd.rd_scan ? cmd.step : idx_r;
  assign wr_addr  = cmd.wr_rnd ? rnd_addr : idx_r;
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= tlbs_pkg::func_t'(in_func);
      idx_r  <= in_entry_index;
      new_r  <= tlbs_pkg::unpack_entry(in_entry_hi, in_entry_lo_even,
                                       in_entry_lo_odd, in_page_mask);
      dvd_r  <= in_cycle_count[31:1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, divisor}) rem_r <= REM_W'(trial - {1'b0, divisor});
      else                          rem_r <= REM_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= new_r;
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // cleared entries read as zero until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.wr_en) valid_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign status.func = func_r;
  assign status.hit  = tlbs_pkg::entry_match(rd_entry, new_r.vpn, new_r.asid);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_index_r   <= in_entry_index;
      res_miss_r    <= (tlbs_pkg::func_t'(in_func) == tlbs_pkg::FUNC_PROBE);
      res_hi_r      <= '0;
      res_lo_even_r <= '0;
      res_lo_odd_r  <= '0;
      res_mask_r    <= '0;
    end else begin
      if (cmd.wr_en) res_index_r <= wr_addr;
      if (cmd.cmp_en && status.hit) begin
        res_index_r <= rd_idx_r;
        res_miss_r  <= 1'b0;
      end
      if (cmd.rd_capture) begin
        res_hi_r      <= {rd_entry.vpn, 5'd0, rd_entry.asid};
        res_lo_even_r <= {rd_entry.frame_even, rd_entry.attr_even, rd_entry.glob};
        res_lo_odd_r  <= {rd_entry.frame_odd, rd_entry.attr_odd, rd_entry.glob};
        res_mask_r    <= {rd_entry.mask, 13'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_index_out   <= res_index_r;
      out_probe_miss  <= res_miss_r;
      out_hi_out      <= res_hi_r;
      out_lo_even_out <= res_lo_even_r;
      out_lo_odd_out  <= res_lo_odd_r;
      out_mask_out    <= res_mask_r;
    end
  end

endmodule

// ===== sv/tlb_entry_store_with_probe.sv =====
// channel   direction  handshake            beat contents
// in        input      in_valid / in_stall  func, entry index, entry-hi/lo words, mask, count
// out       output     out_valid/out_stall  index, probe miss, hi/lo words, mask
// cfg       input      cfg_valid/cfg_ready  wired limit
//
// One item at a time. Read: decode, store read, capture. Indexed write: decode, write.
// Random write: one remainder bit per cycle over the 31-bit count / 2, then the write.
// Probe: one entry per cycle through the single read port of the entry store, up to a hit.
// A finished result sits in the output register; the next beat is taken meanwhile.
// Reset is synchronous; per-entry valid bits clear the whole store at once.
// cfg_ready is always high.
module tlb_entry_store_with_probe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_wired_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_entry_index,
  input  logic [31:0] in_entry_hi,
  input  logic [31:0] in_entry_lo_even,
  input  logic [31:0] in_entry_lo_odd,
  input  logic [31:0] in_page_mask,
  input  logic [31:0] in_cycle_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_index_out,
  output logic        out_probe_miss,
  output logic [31:0] out_hi_out,
  output logic [29:0] out_lo_even_out,
  output logic [29:0] out_lo_odd_out,
  output logic [24:0] out_mask_out
);

  tlbs_pkg::ctl_cmd_t   cmd;
  tlbs_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tlbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlbs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_wired_limit  (cfg_wired_limit),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_entry_hi      (in_entry_hi),
    .in_entry_lo_even (in_entry_lo_even),
    .in_entry_lo_odd  (in_entry_lo_odd),
    .in_page_mask     (in_page_mask),
    .in_cycle_count   (in_cycle_count),
    .cmd              (cmd),
    .status           (status),
    .out_index_out    (out_index_out),
    .out_probe_miss   (out_probe_miss),
    .out_hi_out       (out_hi_out),
    .out_lo_even_out  (out_lo_even_out),
    .out_lo_odd_out   (out_lo_odd_out),
    .out_mask_out     (out_mask_out)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("beat accepted while an item is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("result published over a waiting beat");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_probe_miss) |->
      (out_hi_out == '0 && out_lo_even_out == '0 && out_lo_odd_out == '0 &&
       out_mask_out == '0))
    else $error("probe miss carries read data");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int OPS_PER_PHASE  = 200;
  localparam int TAIL_CYCLES    = 60;

  typedef struct packed {
    tlbs_pkg::func_t func;
    logic [4:0]      idx;
    logic [31:0]     hi;
    logic [31:0]     lo_even;
    logic [31:0]     lo_odd;
    logic [31:0]     pmask;
    logic [31:0]     count;
  } tlb_op_t;

  typedef struct packed {
    logic [4:0]  index;
    logic        miss;
    logic [31:0] hi;
    logic [29:0] lo_even;
    logic [29:0] lo_odd;
    logic [24:0] mask;
  } tlb_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_wired_limit = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [4:0]  in_entry_index = '0;
  logic [31:0] in_entry_hi = '0;
  logic [31:0] in_entry_lo_even = '0;
  logic [31:0] in_entry_lo_odd = '0;
  logic [31:0] in_page_mask = '0;
  logic [31:0] in_cycle_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_index_out;
  logic        out_probe_miss;
  logic [31:0] out_hi_out;
  logic [29:0] out_lo_even_out;
  logic [29:0] out_lo_odd_out;
  logic [24:0] out_mask_out;

  tlb_entry_store_with_probe dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_wired_limit  (cfg_wired_limit),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_entry_hi      (in_entry_hi),
    .in_entry_lo_even (in_entry_lo_even),
    .in_entry_lo_odd  (in_entry_lo_odd),
    .in_page_mask     (in_page_mask),
    .in_cycle_count   (in_cycle_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index_out    (out_index_out),
    .out_probe_miss   (out_probe_miss),
    .out_hi_out       (out_hi_out),
    .out_lo_even_out  (out_lo_even_out),
    .out_lo_odd_out   (out_lo_odd_out),
    .out_mask_out     (out_mask_out)
  );

  // shadow copy of the entry store and the wired register
  logic [18:0] sh_vpn        [tlbs_pkg::ENTRIES];
  logic [11:0] sh_mask       [tlbs_pkg::ENTRIES];
  logic [7:0]  sh_asid       [tlbs_pkg::ENTRIES];
  logic        sh_glob       [tlbs_pkg::ENTRIES];
  logic [23:0] sh_frame_even [tlbs_pkg::ENTRIES];
  logic [23:0] sh_frame_odd  [tlbs_pkg::ENTRIES];
  logic [4:0]  sh_attr_even  [tlbs_pkg::ENTRIES];
  logic [4:0]  sh_attr_odd   [tlbs_pkg::ENTRIES];
  logic [4:0]  sh_wired;

  tlb_op_t     tlb_ops_q[$];
  tlb_reply_t  tlb_replies_q[$];
  logic [31:0] written_hi[$];

  logic        op_beat_taken = 1'b0;
  logic        cfg_beat_taken = 1'b0;
  int          send_idle_pct = 10;
  int          sink_stall_pct = 15;
  int          send_idle_left = 0;
  int          sink_stall_left = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          n_read = 0, n_wr_idx = 0, n_wr_rnd = 0, n_hit = 0, n_miss = 0;
  int          mid_wired;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("tlb_entry_store_with_probe: mismatch");
      $finish;
    end
  end

  function automatic tlb_reply_t run_tlb_op(input tlb_op_t op);
    tlb_reply_t  r;
    int unsigned slot;
    int unsigned span;
    logic [18:0] keep;
    logic        found;
    r = '0;
    slot = op.idx % tlbs_pkg::ENTRIES;
    r.index = 5'(slot);
    case (op.func)
      tlbs_pkg::FUNC_READ: begin
        r.mask    = {sh_mask[slot], 13'd0};
        r.hi      = {sh_vpn[slot], 5'd0, sh_asid[slot]};
        r.lo_even = {sh_frame_even[slot], sh_attr_even[slot], sh_glob[slot]};
        r.lo_odd  = {sh_frame_odd[slot], sh_attr_odd[slot], sh_glob[slot]};
      end
      tlbs_pkg::FUNC_WR_IDX, tlbs_pkg::FUNC_WR_RND: begin
        if (op.func == tlbs_pkg::FUNC_WR_RND) begin
          if (sh_wired >= tlbs_pkg::ENTRIES) begin
            slot = tlbs_pkg::ENTRIES - 1;
          end else begin
            span = tlbs_pkg::ENTRIES - sh_wired;
            slot = ((op.count >> 1) % span) + sh_wired;
          end
        end
        sh_vpn[slot]        = op.hi[31:13];
        sh_asid[slot]       = op.hi[7:0];
        sh_mask[slot]       = op.pmask[24:13];
        sh_glob[slot]       = op.lo_even[0] & op.lo_odd[0];
        sh_frame_even[slot] = op.lo_even[29:6];
        sh_frame_odd[slot]  = op.lo_odd[29:6];
        sh_attr_even[slot]  = op.lo_even[5:1];
        sh_attr_odd[slot]   = op.lo_odd[5:1];
        r.index = 5'(slot);
      end
      default: begin
        found = 1'b0;
        for (int e = 0; e < tlbs_pkg::ENTRIES; e++) begin
          keep = ~{7'd0, sh_mask[e]};
          if (!found && (sh_vpn[e] & keep) == (op.hi[31:13] & keep) &&
              (sh_glob[e] || sh_asid[e] == op.hi[7:0])) begin
            found = 1'b1;
            r.index = 5'(e);
          end
        end
        if (!found) begin
          r.miss  = 1'b1;
          r.index = op.idx;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: hold a stalled beat, otherwise idle in bursts or present the next op
  always @(negedge clk) begin : op_driver
    tlb_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !op_beat_taken) begin
      in_valid <= 1'b1;
    end else if (send_idle_left != 0) begin
      in_valid <= 1'b0;
      send_idle_left <= send_idle_left - 1;
    end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      send_idle_left <= $urandom_range(0, 15);
    end else if (tlb_ops_q.size() != 0) begin
      op = tlb_ops_q.pop_front();
      in_valid         <= 1'b1;
      in_func          <= op.func;
      in_entry_index   <= op.idx;
      in_entry_hi      <= op.hi;
      in_entry_lo_even <= op.lo_even;
      in_entry_lo_odd  <= op.lo_odd;
      in_page_mask     <= op.pmask;
      in_cycle_count   <= op.count;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (sink_stall_left != 0) begin
      out_stall <= 1'b1;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      out_stall <= 1'b1;
      sink_stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    tlb_op_t    op;
    tlb_reply_t want;
    op_beat_taken  <= rst_n && in_valid && !in_stall;
    cfg_beat_taken <= rst_n && cfg_valid && cfg_ready;
    if (!rst_n) begin
      for (int e = 0; e < tlbs_pkg::ENTRIES; e++) begin
        sh_vpn[e] = '0;
        sh_mask[e] = '0;
        sh_asid[e] = '0;
        sh_glob[e] = 1'b0;
        sh_frame_even[e] = '0;
        sh_frame_odd[e] = '0;
        sh_attr_even[e] = '0;
        sh_attr_odd[e] = '0;
      end
      sh_wired = '0;
    end else begin
      if (cfg_valid && cfg_ready)
        sh_wired = cfg_wired_limit;
      // compare before pushing so a result can never match its own request edge
      if (out_valid && !out_stall) begin
        if (tlb_replies_q.size() == 0) begin
          $error("result beat with none pending: index_out 0x%0h", out_index_out);
          mismatches++;
        end else begin
          want = tlb_replies_q.pop_front();
          check_field("index_out", want.index, out_index_out);
          check_field("probe_miss", want.miss, out_probe_miss);
          check_field("hi_out", want.hi, out_hi_out);
          check_field("lo_even_out", want.lo_even, out_lo_even_out);
          check_field("lo_odd_out", want.lo_odd, out_lo_odd_out);
          check_field("mask_out", want.mask, out_mask_out);
        end
      end
      if (in_valid && !in_stall) begin
        op.func    = tlbs_pkg::func_t'(in_func);
        op.idx     = in_entry_index;
        op.hi      = in_entry_hi;
        op.lo_even = in_entry_lo_even;
        op.lo_odd  = in_entry_lo_odd;
        op.pmask   = in_page_mask;
        op.count   = in_cycle_count;
        want = run_tlb_op(op);
        tlb_replies_q.push_back(want);
        case (op.func)
          tlbs_pkg::FUNC_READ:   n_read++;
          tlbs_pkg::FUNC_WR_IDX: n_wr_idx++;
          tlbs_pkg::FUNC_WR_RND: n_wr_rnd++;
          default: if (want.miss) n_miss++; else n_hit++;
        endcase
      end
    end
  end

  task automatic push_op(input tlbs_pkg::func_t f, input logic [4:0] idx,
                         input logic [31:0] hi,
                         input logic [31:0] lo0, input logic [31:0] lo1,
                         input logic [31:0] pm, input logic [31:0] cnt);
    tlb_op_t op;
    op.func = f;
    op.idx = idx;
    op.hi = hi;
    op.lo_even = lo0;
    op.lo_odd = lo1;
    op.pmask = pm;
    op.count = cnt;
    tlb_ops_q.push_back(op);
  endtask

  // mostly write-then-probe traffic: probes reuse recently written entry-hi values
  task automatic push_random_op();
    tlb_op_t     op;
    int unsigned pick;
    int unsigned k;
    op.func    = tlbs_pkg::func_t'($urandom_range(0, 3));
    op.idx     = 5'($urandom);
    op.hi      = $urandom;
    op.lo_even = $urandom;
    op.lo_odd  = $urandom;
    op.pmask   = $urandom;
    op.count   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op.func = ($urandom_range(0, 1) != 0) ? tlbs_pkg::FUNC_WR_IDX : tlbs_pkg::FUNC_WR_RND;
      if ($urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, 6);
        op.pmask = ((32'd1 << (2 * k)) - 32'd1) << 13;
        if ($urandom_range(0, 3) == 0)
          op.pmask = op.pmask | ($urandom & ~32'h01FF_E000);
      end
      if ($urandom_range(0, 1) != 0) begin
        op.lo_even[0] = 1'b1;
        op.lo_odd[0]  = 1'b1;
      end
      written_hi.push_back(op.hi);
      if (written_hi.size() > 48)
        void'(written_hi.pop_front());
    end else if (pick < 70) begin
      op.func = tlbs_pkg::FUNC_PROBE;
      if (written_hi.size() != 0 && $urandom_range(0, 3) != 0) begin
        op.hi = written_hi[$urandom_range(0, written_hi.size() - 1)];
        if ($urandom_range(0, 3) == 0)
          op.hi[7:0] = 8'($urandom);
        if ($urandom_range(0, 2) == 0)
          op.hi = op.hi ^ ($urandom & 32'h0007_E000);
      end else if ($urandom_range(0, 7) == 0) begin
        op.hi = '0;
      end
    end else if (pick < 92) begin
      op.func = tlbs_pkg::FUNC_READ;
    end
    tlb_ops_q.push_back(op);
  endtask

  // sample at the rising edge, where the driver's valid is settled
  task automatic wait_idle();
    do @(posedge clk);
    while (tlb_ops_q.size() != 0 || in_valid || tlb_replies_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_wired(input logic [4:0] limit);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wired_limit <= limit;
    do @(negedge clk);
    while (!cfg_beat_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [4:0] limit, input int idle_pct,
                                  input int stall_pct);
    wait_idle();
    set_wired(limit);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < OPS_PER_PHASE; i++)
      push_random_op();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_wired(5'd0);

    // cleared entries: vpn 0 / asid 0 hits entry 0, any other asid misses
    push_op(tlbs_pkg::FUNC_PROBE,  5'd7,  32'h0000_0000, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd31, 32'h0000_00FF, '1, '1, '1, '1);
    push_op(tlbs_pkg::FUNC_READ,   5'd31, '0, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_WR_IDX, 5'd0,  '1, '1, '1, '1, '1);
    push_op(tlbs_pkg::FUNC_READ,   5'd0,  '1, '1, '1, '1, '1);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd3,  32'h0000_00AB, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd4,  32'hFE00_0055, '0, '0, '0, '0);
    // global bit only when both lo words carry it
    push_op(tlbs_pkg::FUNC_WR_IDX, 5'd1,  32'h2468_A0C3, 32'h1555_5555, 32'h2AAA_AAAA,
            32'h0000_6000, '0);
    push_op(tlbs_pkg::FUNC_READ,   5'd1,  '0, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd9,  32'h2468_A0C3, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd10, 32'h2468_A0C4, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd11, 32'h2468_C0C3, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_WR_RND, 5'd5,  32'h1357_9BDF, 32'h3FFF_FFC1, 32'hC000_0001,
            32'hFE00_1FFF, 32'h0000_0000);
    push_op(tlbs_pkg::FUNC_WR_RND, 5'd6,  32'h8000_0080, 32'h0000_003E, 32'h0000_0038,
            32'h01FF_E000, 32'hFFFF_FFFF);
    push_op(tlbs_pkg::FUNC_READ,   5'd31, '0, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_READ,   5'd0,  '1, '1, '1, '1, '1);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd12, 32'h8000_0080, '0, '0, '0, '0);
    wait_idle();

    // every random write lands on the top entry when the wired limit is at its maximum
    set_wired(5'd31);
    push_op(tlbs_pkg::FUNC_WR_RND, 5'd0,  32'hDEAD_B0EF, 32'h2345_6789, 32'h0ABC_DEF1,
            32'h0007_E000, 32'h1234_5679);
    push_op(tlbs_pkg::FUNC_WR_RND, 5'd2,  32'h0BAD_F00D, 32'h0000_0001, 32'h0000_0001,
            32'h0000_0000, 32'h0000_0002);
    push_op(tlbs_pkg::FUNC_READ,   5'd31, '0, '0, '0, '0, '0);
    push_op(tlbs_pkg::FUNC_PROBE,  5'd17, 32'h0BAD_F0AA, '0, '0, '0, '0);
    for (int i = 0; i < OPS_PER_PHASE; i++)
      push_random_op();

    mid_wired = $urandom_range(2, 30);
    run_random_phase(5'd0, 12, 20);
    run_random_phase(5'(mid_wired), 0, 0);
    run_random_phase(5'd1, 25, 30);
    run_random_phase(5'd16, 0, 0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d reads, %0d indexed writes, %0d random writes, %0d probes",
             n_read, n_wr_idx, n_wr_rnd, n_hit + n_miss);
    $display("probes hit %0d, missed %0d; wired limit set to 0, 31, %0d, 1 and 16",
             n_hit, n_miss, mid_wired);
    if (mismatches == 0 && tlb_replies_q.size() == 0) begin
      $display("tlb_entry_store_with_probe: match");
    end else begin
      $display("tlb_entry_store_with_probe: mismatch");
    end
    $finish;
  end

endmodule
